FILE: hdl/pmma_pkg.sv
// ----------------------------------------------------------------------------
// pmma_pkg: shared types and constants for the paged memory access block
// Opcodes, status codes and field widths used by the interfaces and the RTL.
// ----------------------------------------------------------------------------
package pmma_pkg;

  localparam int unsigned LANES   = 8;
  localparam int unsigned LANE_W  = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned OPC_W   = 2;
  localparam int unsigned SIZE_W  = 2;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned COUNT_W = 4;

  typedef enum logic [OPC_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CAS   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  localparam int unsigned PAGES_RESET = 16;

endpackage

FILE: hdl/pmma_if.sv
// ----------------------------------------------------------------------------
// pmma interfaces: request, response and configuration channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pmma_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [pmma_pkg::OPC_W-1:0]           opcode;
  logic [pmma_pkg::SIZE_W-1:0]          size_code;
  logic [pmma_pkg::ADDR_W-1:0]          address;
  logic [pmma_pkg::DATA_W-1:0]          write_value;
  logic [pmma_pkg::BYTE_W-1:0]          expected_byte;

  modport source (output valid, opcode, size_code, address, write_value, expected_byte,
                  input ready);
  modport sink   (input valid, opcode, size_code, address, write_value, expected_byte,
                  output ready);
endinterface

interface pmma_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pmma_pkg::DATA_W-1:0] read_value;
  logic                        status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

interface pmma_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pmma_pkg::CFG_W-1:0] pages_in_use;

  modport source (output valid, pages_in_use, input ready);
  modport sink   (input valid, pages_in_use, output ready);
endinterface

FILE: hdl/paged_multiwidth_memory_access.sv
// ----------------------------------------------------------------------------
// paged_multiwidth_memory_access: paged byte memory, unaligned 1/2/4/8 byte access
// Eight byte-lane banks serve read, write and byte compare-and-swap words.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one access word (opcode, size, byte address, data, expected
//   byte). rsp_o returns one word per request: little-endian read data and a
//   status bit (refused when the first or last page touched is not in use).
//   cfg_i writes pages_in_use; it is always ready and must be written only
//   while no request is in flight.
// Timing:
//   A request is taken in the idle cycle; the byte lanes are read or written
//   at that edge, and the merge state then merges read data (and writes back a
//   swap byte) into the response register when it can be loaded. The block
//   takes no new request until that load, set by the single-port lane banks
//   used for read then write-back.
// Stall:
//   The response register holds while rsp_o.ready is low; the block waits in
//   its merge state and takes no new request until the response can be loaded.
// Reset:
//   Clears control state and sets pages_in_use to 16 (capped at MAX_PAGES).
//   Memory contents are undefined until written; no clearing pass is done.
// ----------------------------------------------------------------------------
module paged_multiwidth_memory_access #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAX_PAGES  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pmma_req_if.sink    req_i,
  pmma_rsp_if.source  rsp_o,
  pmma_cfg_if.sink    cfg_i
);

  localparam int unsigned LANES     = pmma_pkg::LANES;
  localparam int unsigned LANE_W    = pmma_pkg::LANE_W;
  localparam int unsigned BYTE_W    = pmma_pkg::BYTE_W;
  localparam int unsigned DATA_W    = pmma_pkg::DATA_W;
  localparam int unsigned ADDR_W    = pmma_pkg::ADDR_W;
  localparam int unsigned COUNT_W   = pmma_pkg::COUNT_W;
  localparam int unsigned MEM_BYTES = MAX_PAGES * PAGE_BYTES;
  localparam int unsigned ROWS      = (MEM_BYTES + LANES - 1) / LANES;
  localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LIMIT_W   = $clog2(MEM_BYTES + 1);
  localparam int unsigned PG_W      = $clog2(MAX_PAGES + 1);
  localparam int unsigned RST_PAGES = (MAX_PAGES < pmma_pkg::PAGES_RESET) ?
                                      MAX_PAGES : pmma_pkg::PAGES_RESET;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(RST_PAGES * PAGE_BYTES);

  typedef enum logic {S_IDLE, S_RESP} state_e;

  state_e                state_q;
  logic                  rsp_valid_q;
  logic [DATA_W-1:0]     rdata_q;
  logic                  status_q;
  logic [LIMIT_W-1:0]    limit_q;

  // request held for the merge cycle
  logic [pmma_pkg::OPC_W-1:0] op_q;
  logic [LANE_W-1:0]     a0_q;
  logic [COUNT_W-1:0]    n_q;
  logic [ROW_W-1:0]      row0_q;
  logic [BYTE_W-1:0]     wbyte_q;
  logic [BYTE_W-1:0]     exp_q;
  logic                  go_q;
  logic                  refused_q;

  logic                  accept;
  logic                  leave;
  logic [COUNT_W-1:0]    in_n;
  logic [ADDR_W:0]       in_last;
  logic                  in_ok;
  logic                  in_op_none;
  logic                  mem_go;
  logic [ROW_W-1:0]      in_row0;
  logic [ROW_W-1:0]      in_row1;
  logic [PG_W-1:0]       pages_eff;
  logic [DATA_W-1:0]     merge_data;

  logic [ROW_W-1:0]      lane_addr  [LANES];
  logic [BYTE_W-1:0]     lane_wdata [LANES];
  logic [LANES-1:0]      lane_we;
  logic [LANES-1:0]      lane_re;
  logic [BYTE_W-1:0]     rd_q       [LANES];

  assign accept       = req_i.valid && req_i.ready;
  assign req_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign leave        = (state_q == S_RESP) && (!rsp_valid_q || rsp_o.ready);

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_value = rdata_q;
  assign rsp_o.status     = status_q;

  // span check against the configured limit
  always_comb begin
    if (req_i.opcode == pmma_pkg::OP_CAS) begin
      in_n = COUNT_W'(1);
    end else begin
      in_n = COUNT_W'(1) << req_i.size_code;
    end
    in_last    = {1'b0, req_i.address} + (ADDR_W + 1)'(in_n) - (ADDR_W + 1)'(1);
    in_ok      = in_last < (ADDR_W + 1)'(limit_q);
    in_op_none = (req_i.opcode == pmma_pkg::OP_NONE);
    mem_go     = accept && in_ok && !in_op_none;
    in_row0    = req_i.address[ROW_W+2:3];
    in_row1    = in_row0 + ROW_W'(1);
  end

  always_comb begin
    if (32'(cfg_i.pages_in_use) > MAX_PAGES) begin
      pages_eff = PG_W'(MAX_PAGES);
    end else begin
      pages_eff = PG_W'(cfg_i.pages_in_use);
    end
  end

  // lane steering: byte k of the word sits in lane (address + k) mod 8
  always_comb begin
    logic [LANE_W-1:0] k;
    logic              used;
    for (int l = 0; l < LANES; l++) begin
      k    = LANE_W'(l) - req_i.address[LANE_W-1:0];
      used = {1'b0, k} < in_n;
      if (state_q == S_RESP) begin
        lane_addr[l]  = row0_q;
        lane_wdata[l] = wbyte_q;
        lane_re[l]    = 1'b0;
        lane_we[l]    = leave && go_q && (op_q == pmma_pkg::OP_CAS) &&
                        (LANE_W'(l) == a0_q) && (rd_q[l] == exp_q);
      end else begin
        lane_addr[l]  = (LANE_W'(l) < req_i.address[LANE_W-1:0]) ? in_row1 : in_row0;
        lane_wdata[l] = req_i.write_value[{k, 3'b000} +: BYTE_W];
        lane_re[l]    = mem_go && used && (req_i.opcode != pmma_pkg::OP_WRITE);
        lane_we[l]    = mem_go && used && (req_i.opcode == pmma_pkg::OP_WRITE);
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [BYTE_W-1:0] lane_mem [ROWS];

    always_ff @(posedge clk_i) begin
      if (lane_we[l]) begin
        lane_mem[lane_addr[l]] <= lane_wdata[l];
      end
      if (lane_re[l]) begin
        rd_q[l] <= lane_mem[lane_addr[l]];
      end
    end
  end

  // gather lanes back into little-endian order
  always_comb begin
    logic [LANE_W-1:0] lane;
    merge_data = '0;
    for (int k = 0; k < LANES; k++) begin
      lane = a0_q + LANE_W'(k);
      if (go_q && (op_q == pmma_pkg::OP_READ) && (COUNT_W'(k) < n_q)) begin
        merge_data[k*BYTE_W +: BYTE_W] = rd_q[lane];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= req_i.opcode;
      a0_q      <= req_i.address[LANE_W-1:0];
      n_q       <= in_n;
      row0_q    <= in_row0;
      wbyte_q   <= req_i.write_value[BYTE_W-1:0];
      exp_q     <= req_i.expected_byte;
      go_q      <= in_ok && !in_op_none;
      refused_q <= !in_ok && !in_op_none;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      rdata_q     <= '0;
      status_q    <= pmma_pkg::STATUS_DONE;
      limit_q     <= LIMIT_RESET;
    end else begin
      if (cfg_i.valid) begin
        limit_q <= LIMIT_W'(pages_eff * PAGE_BYTES);
      end
      case (state_q)
        S_IDLE: begin
          if (rsp_o.ready) begin
            rsp_valid_q <= 1'b0;
          end
          if (accept) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (leave) begin
            rsp_valid_q <= 1'b1;
            rdata_q     <= merge_data;
            status_q    <= refused_q ? pmma_pkg::STATUS_REFUSED : pmma_pkg::STATUS_DONE;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/pmma_checker.sv
// ----------------------------------------------------------------------------
// pmma_checker: port-level checks for the paged memory access block
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module pmma_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [63:0] rsp_read_value_i,
  input  logic        rsp_status_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  // a pending response word must hold until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_read_value_i)
                                    && $stable(rsp_status_i))
    else $error("response word changed while stalled");

  // one request in flight: no second request right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request accepted while previous one in flight");

  // with no response pending, the answer is loaded straight from the merge state
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && !rsp_valid_i |-> ##2 rsp_valid_i)
    else $error("response missing after request");

  // refused accesses never return data
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i |-> rsp_read_value_i == 64'd0)
    else $error("refused access returned data");

endmodule

bind paged_multiwidth_memory_access pmma_checker u_pmma_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_read_value_i (rsp_o.read_value),
  .rsp_status_i     (rsp_o.status)
);

FILE: tb/tb_paged_multiwidth_memory_access.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paged_multiwidth_memory_access: self-checking bench for the paged memory
// Drives read, write, byte swap and no-op words through the request channel
// and keeps a byte-level copy of the memory and page limit. Each response word
// is checked against the predicted read data and status. Several page limits
// are used, with random idle and stall cycles and one long response hold.
// ----------------------------------------------------------------------------
module tb_paged_multiwidth_memory_access;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned MAX_PAGES  = 16;
  localparam int unsigned MEM_BYTES  = PAGE_BYTES * MAX_PAGES;
  localparam int unsigned QUIET      = 8;
  localparam int unsigned HOLD_LEN   = 300;

  typedef struct {
    pmma_pkg::opcode_e opcode;
    bit [1:0]          size_code;
    bit [31:0]         address;
    bit [63:0]         write_value;
    bit [7:0]          expected_byte;
  } access_t;

  // byte image of the memory plus the page limit; predicts each response word
  class paged_mem_model;
    bit [7:0]    mem_bytes [MEM_BYTES];
    bit          written [MEM_BYTES];
    int unsigned pages = pmma_pkg::PAGES_RESET;
    bit [63:0]   exp_read_value_q [$];
    bit          exp_status_q [$];
    int unsigned errors;
    int unsigned n_checked;
    int unsigned n_refused;
    int unsigned n_op [4];

    function int unsigned eff_pages();
      return (pages > MAX_PAGES) ? MAX_PAGES : pages;
    endfunction

    function bit span_ok(bit [31:0] addr, int unsigned count);
      longint unsigned last;
      last = longint'(addr) + count - 1;
      return last < longint'(eff_pages()) * PAGE_BYTES;
    endfunction

    function bit all_written(bit [31:0] addr, int unsigned count);
      for (int unsigned i = 0; i < count; i++)
        if (!written[addr + i]) return 1'b0;
      return 1'b1;
    endfunction

    function bit [7:0] peek(bit [31:0] addr);
      return mem_bytes[addr];
    endfunction

    function int unsigned pending();
      return exp_status_q.size();
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%t  %s", $realtime, msg);
    endfunction

    function void note_access(access_t a);
      bit [63:0]   value;
      bit          status;
      int unsigned nbytes;
      int unsigned idx;
      value  = '0;
      status = pmma_pkg::STATUS_DONE;
      nbytes = 1 << a.size_code;
      n_op[a.opcode]++;
      case (a.opcode)
        pmma_pkg::OP_READ, pmma_pkg::OP_WRITE: begin
          if (!span_ok(a.address, nbytes)) begin
            status = pmma_pkg::STATUS_REFUSED;
          end else begin
            for (int unsigned i = 0; i < nbytes; i++) begin
              idx = a.address + i;
              if (a.opcode == pmma_pkg::OP_READ) begin
                value[8*i +: 8] = mem_bytes[idx];
              end else begin
                mem_bytes[idx] = a.write_value[8*i +: 8];
                written[idx]   = 1'b1;
              end
            end
          end
        end
        pmma_pkg::OP_CAS: begin
          // always one byte, size ignored
          if (!span_ok(a.address, 1)) status = pmma_pkg::STATUS_REFUSED;
          else if (mem_bytes[a.address] == a.expected_byte)
            mem_bytes[a.address] = a.write_value[7:0];
        end
        default: ;
      endcase
      if (status == pmma_pkg::STATUS_REFUSED) n_refused++;
      exp_read_value_q.push_back(value);
      exp_status_q.push_back(status);
    endfunction

    function void check_response(bit [63:0] value, bit status);
      bit [63:0] exp_value;
      bit        exp_status;
      if (exp_status_q.size() == 0) begin
        fail($sformatf("response word with nothing outstanding: value %h status %0d",
                       value, status));
        return;
      end
      exp_value  = exp_read_value_q.pop_front();
      exp_status = exp_status_q.pop_front();
      n_checked++;
      if (value !== exp_value)
        fail($sformatf("read_value mismatch: expected %h, got %h", exp_value, value));
      if (status !== exp_status)
        fail($sformatf("status mismatch: expected %0d, got %0d", exp_status, status));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pmma_req_if req ();
  pmma_rsp_if rsp ();
  pmma_cfg_if cfg ();

  paged_multiwidth_memory_access #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_PAGES  (MAX_PAGES)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  paged_mem_model model;
  int unsigned    send_idle_pct;
  int unsigned    rsp_stall_pct;
  int unsigned    hold_request;
  int unsigned    hold_left;
  int unsigned    n_cfg_writes;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // response side: check each accepted word, then pick next ready
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) model.check_response(rsp.read_value, rsp.status);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  task automatic send_access(input access_t a);
    req.valid         <= 1'b1;
    req.opcode        <= a.opcode;
    req.size_code     <= a.size_code;
    req.address       <= a.address;
    req.write_value   <= a.write_value;
    req.expected_byte <= a.expected_byte;
    do @(posedge clk); while (!req.ready);
    model.note_access(a);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_fields(input pmma_pkg::opcode_e op, input bit [1:0] sz,
                             input bit [31:0] addr, input bit [63:0] wv,
                             input bit [7:0] eb);
    access_t a;
    a.opcode        = op;
    a.size_code     = sz;
    a.address       = addr;
    a.write_value   = wv;
    a.expected_byte = eb;
    send_access(a);
  endtask

  // page limit changes only with the block drained
  task automatic write_pages(input bit [4:0] value);
    req.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
    cfg.valid        <= 1'b1;
    cfg.pages_in_use <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    model.pages = value;
    n_cfg_writes++;
  endtask

  // mostly accesses near page boundaries, some anywhere in the 32-bit space
  function automatic access_t random_access();
    access_t     a;
    int unsigned pick;
    int unsigned pmax;
    int unsigned p;
    int unsigned n;
    a.size_code     = 2'($urandom_range(3));
    a.write_value   = {$urandom, $urandom};
    a.expected_byte = 8'($urandom_range(255));
    pmax            = model.eff_pages();
    if ($urandom_range(99) < 8) begin
      a.opcode  = pmma_pkg::opcode_e'($urandom_range(3));
      a.address = $urandom;
    end else begin
      pick     = $urandom_range(99);
      a.opcode = (pick < 40) ? pmma_pkg::OP_WRITE : (pick < 80) ? pmma_pkg::OP_READ :
                 (pick < 95) ? pmma_pkg::OP_CAS : pmma_pkg::OP_NONE;
      if (pmax != 0 && $urandom_range(9) == 0) begin
        a.address = $urandom_range(pmax * PAGE_BYTES - 1);
      end else begin
        p         = $urandom_range(pmax);
        a.address = p * PAGE_BYTES + $urandom_range(31);
        if (p != 0) a.address -= 16;
      end
    end
    // never read a byte that was not written yet
    n = (a.opcode == pmma_pkg::OP_CAS) ? 1 : (1 << a.size_code);
    if ((a.opcode == pmma_pkg::OP_READ || a.opcode == pmma_pkg::OP_CAS) &&
        model.span_ok(a.address, n)) begin
      if (!model.all_written(a.address, n)) a.opcode = pmma_pkg::OP_WRITE;
      else if (a.opcode == pmma_pkg::OP_CAS && $urandom_range(1) == 1)
        a.expected_byte = model.peek(a.address);
    end
    return a;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_access(random_access());
  endtask

  initial begin
    int unsigned mid_pages;
    model             = new();
    rst_n             = 1'b0;
    req.valid         = 1'b0;
    req.opcode        = pmma_pkg::OP_NONE;
    req.size_code     = '0;
    req.address       = '0;
    req.write_value   = '0;
    req.expected_byte = '0;
    rsp.ready         = 1'b0;
    cfg.valid         = 1'b0;
    cfg.pages_in_use  = '0;
    send_idle_pct     = 0;
    rsp_stall_pct     = 0;
    hold_request      = 0;
    hold_left         = 0;
    n_cfg_writes      = 0;
    mid_pages         = $urandom_range(2, 15);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset page limit
    send_fields(pmma_pkg::OP_WRITE, 2'd3, 32'h0000_0000, 64'h0123_4567_89AB_CDEF, 8'h00);
    send_fields(pmma_pkg::OP_READ,  2'd3, 32'h0000_0000, 64'h0, 8'h00);
    send_fields(pmma_pkg::OP_READ,  2'd0, 32'h0000_0007, 64'h0, 8'h00);
    send_fields(pmma_pkg::OP_READ,  2'd1, 32'h0000_0001, 64'h0, 8'h00);
    send_fields(pmma_pkg::OP_READ,  2'd2, 32'h0000_0003, 64'h0, 8'h00);
    // crossing from page 0 into page 1
    send_fields(pmma_pkg::OP_WRITE, 2'd3, 32'h0000_0FFC, '1, 8'hFF);
    send_fields(pmma_pkg::OP_READ,  2'd3, 32'h0000_0FFC, 64'h0, 8'h00);
    send_fields(pmma_pkg::OP_READ,  2'd2, 32'h0000_0FFE, 64'h0, 8'h00);
    send_fields(pmma_pkg::OP_READ,  2'd1, 32'h0000_0FFF, 64'h0, 8'h00);
    // top of memory
    send_fields(pmma_pkg::OP_WRITE, 2'd3, 32'h0000_FFF8, 64'h0, 8'h00);
    send_fields(pmma_pkg::OP_READ,  2'd3, 32'h0000_FFF8, 64'h0, 8'h00);
    send_fields(pmma_pkg::OP_WRITE, 2'd1, 32'h0000_FFFF, '1, 8'h00);
    send_fields(pmma_pkg::OP_WRITE, 2'd0, 32'h0000_FFFF, 64'h0000_0000_0000_00A5, 8'h00);
    send_fields(pmma_pkg::OP_READ,  2'd0, 32'h0000_FFFF, 64'h0, 8'h00);
    // top of the address space, no wrap
    send_fields(pmma_pkg::OP_READ,  2'd3, 32'hFFFF_FFF8, 64'h0, 8'h00);
    send_fields(pmma_pkg::OP_WRITE, 2'd3, 32'hFFFF_FFFF, '1, 8'hFF);
    // swap hit, swap miss with wide size, swap out of range
    send_fields(pmma_pkg::OP_CAS,   2'd0, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FF5A, 8'hEF);
    send_fields(pmma_pkg::OP_CAS,   2'd3, 32'h0000_0000, 64'h0000_0000_0000_0011, 8'hEF);
    send_fields(pmma_pkg::OP_READ,  2'd0, 32'h0000_0000, 64'h0, 8'h00);
    send_fields(pmma_pkg::OP_CAS,   2'd0, 32'h0001_0000, 64'h0, 8'h00);
    // unused opcode
    send_fields(pmma_pkg::OP_NONE,  2'd3, 32'h0000_0000, '1, 8'hFF);
    send_fields(pmma_pkg::OP_NONE,  2'd0, 32'hFFFF_FFFF, 64'h0, 8'h00);

    run_random(200);

    write_pages(5'd1);
    send_fields(pmma_pkg::OP_WRITE, 2'd2, 32'h0000_0FFE, '1, 8'h00);
    send_fields(pmma_pkg::OP_READ,  2'd2, 32'h0000_0FFC, 64'h0, 8'h00);
    send_fields(pmma_pkg::OP_CAS,   2'd0, 32'h0000_1000, 64'h0, 8'h00);
    send_idle_pct = 52;
    run_random(200);

    // zero pages refuses every read, write and swap
    write_pages(5'd0);
    send_idle_pct = 0;
    rsp_stall_pct = 52;
    send_fields(pmma_pkg::OP_READ, 2'd0, 32'h0000_0000, 64'h0, 8'h00);
    run_random(40);

    // above the maximum acts as the maximum
    write_pages(5'd31);
    send_idle_pct = 20;
    rsp_stall_pct = 20;
    run_random(200);

    write_pages(5'd16);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_request  = HOLD_LEN;
    run_random(200);

    write_pages(5'(mid_pages));
    send_idle_pct = 52;
    run_random(200);

    write_pages(5'd8);
    send_idle_pct = 0;
    rsp_stall_pct = 52;
    run_random(200);

    write_pages(5'd16);
    send_idle_pct = 20;
    rsp_stall_pct = 20;
    run_random(200);

    req.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);

    $display("checked %0d words: %0d reads, %0d writes, %0d swaps, %0d no-ops, %0d refused",
             model.n_checked, model.n_op[pmma_pkg::OP_READ], model.n_op[pmma_pkg::OP_WRITE],
             model.n_op[pmma_pkg::OP_CAS], model.n_op[pmma_pkg::OP_NONE], model.n_refused);
    $display("%0d page limit writes (0, 1, %0d, 8, 16, 31), one %0d-cycle response hold",
             n_cfg_writes, mid_pages, HOLD_LEN);
    if (model.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", model.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout: handshake never completed");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hdl/pmma_pkg.sv
hdl/pmma_if.sv
hdl/paged_multiwidth_memory_access.sv
hdl/pmma_checker.sv
tb/tb_paged_multiwidth_memory_access.sv
